// File: rtl/gsa_pkg.sv
// Package for the generational slot allocator.
// Holds port widths, operation and status codes, default parameter values and the
// controller-to-datapath command type. It depends on nothing.
`default_nettype none

package gsa_pkg;

  localparam int SLOTS_DEF     = 1024;
  localparam int GEN_WIDTH_DEF = 32;

  localparam int FUNC_W = 2;
  localparam int HIDX_W = 10;
  localparam int HGEN_W = 32;
  localparam int STAT_W = 2;
  localparam int LCNT_W = 11;

  localparam logic [FUNC_W-1:0] FUNC_ALLOC   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_RELEASE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_QUERY   = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_STALE = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

  typedef struct packed {
    logic capture;
    logic commit;
  } gsa_cmd_t;

endpackage

`default_nettype wire

// File: rtl/generational_slot_allocator.sv
// Top level of the generational slot allocator.
// Instantiates gsa_ctrl and gsa_dpath and depends on gsa_pkg for widths and defaults.
//
// Each beat runs through a capture step and a commit step: at acceptance the slot word (live mark,
// generation and free-list link, kept together in one single-port-style memory) is read into a
// register, and in the commit step the operation is decided, the word is written back where the
// operation changes it and the result is loaded into the output register. The memory's registered
// read followed by its write-back is why a beat is split this way. A result waiting on out_ready
// holds the commit step, so one operation is in flight at a time. No clearing pass is needed
// after reset; the block is ready as soon as reset is released.
`default_nettype none

module generational_slot_allocator #(
  parameter int SLOTS     = gsa_pkg::SLOTS_DEF,
  parameter int GEN_WIDTH = gsa_pkg::GEN_WIDTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [gsa_pkg::FUNC_W-1:0]  in_func,
  input  wire logic [gsa_pkg::HIDX_W-1:0]  in_handle_index,
  input  wire logic [gsa_pkg::HGEN_W-1:0]  in_handle_generation,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [gsa_pkg::STAT_W-1:0]       out_status,
  output logic [gsa_pkg::HIDX_W-1:0]       out_slot_index,
  output logic [gsa_pkg::HGEN_W-1:0]       out_slot_generation,
  output logic                             out_is_live,
  output logic [gsa_pkg::LCNT_W-1:0]       out_live_count
);
  import gsa_pkg::*;

  gsa_cmd_t cmd;

  gsa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  gsa_dpath #(
    .SLOTS     (SLOTS),
    .GEN_WIDTH (GEN_WIDTH)
  ) u_dpath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .in_func              (in_func),
    .in_handle_index      (in_handle_index),
    .in_handle_generation (in_handle_generation),
    .out_status           (out_status),
    .out_slot_index       (out_slot_index),
    .out_slot_generation  (out_slot_generation),
    .out_is_live          (out_is_live),
    .out_live_count       (out_live_count)
  );

endmodule

`default_nettype wire

// File: rtl/gsa_ctrl.sv
// Controller of the generational slot allocator.
// Sequences each beat through capture and commit and owns the result valid flag.
// Depends on gsa_pkg for the command type.
`default_nettype none

module gsa_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output gsa_pkg::gsa_cmd_t      cmd
);
  import gsa_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  assign in_ready    = (state_r == S_IDLE);
  assign cmd.capture = in_valid && (state_r == S_IDLE);
  assign cmd.commit  = (state_r == S_EXEC) && (!out_valid_r || out_ready);
  assign out_valid   = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (cmd.capture) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (cmd.commit) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/gsa_dpath.sv
// Datapath of the generational slot allocator.
// Holds the slot memory, the free-list head, the high-water mark, the live count and
// the result registers. Depends on gsa_pkg and is driven by gsa_ctrl commands.
`default_nettype none

module gsa_dpath #(
  parameter int SLOTS     = gsa_pkg::SLOTS_DEF,
  parameter int GEN_WIDTH = gsa_pkg::GEN_WIDTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire gsa_pkg::gsa_cmd_t           cmd,
  input  wire logic [gsa_pkg::FUNC_W-1:0]  in_func,
  input  wire logic [gsa_pkg::HIDX_W-1:0]  in_handle_index,
  input  wire logic [gsa_pkg::HGEN_W-1:0]  in_handle_generation,
  output logic [gsa_pkg::STAT_W-1:0]       out_status,
  output logic [gsa_pkg::HIDX_W-1:0]       out_slot_index,
  output logic [gsa_pkg::HGEN_W-1:0]       out_slot_generation,
  output logic                             out_is_live,
  output logic [gsa_pkg::LCNT_W-1:0]       out_live_count
);
  import gsa_pkg::*;

  localparam int IDX_W  = $clog2(SLOTS);
  localparam int LINK_W = IDX_W + 1;
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int WORD_W = 1 + GEN_WIDTH + LINK_W;

  localparam logic [LINK_W-1:0]    LINK_NULL = {LINK_W{1'b1}};
  localparam logic [GEN_WIDTH-1:0] GEN_ONE   = GEN_WIDTH'(1);

  logic [WORD_W-1:0] mem [SLOTS];

  logic [FUNC_W-1:0]  func_r;
  logic [HIDX_W-1:0]  idx_r;
  logic [HGEN_W-1:0]  gen_r;
  logic [WORD_W-1:0]  rd_r;

  logic [LINK_W-1:0]  free_head_r, free_head_nxt;
  logic [CNT_W-1:0]   high_water_r, high_water_nxt;
  logic [CNT_W-1:0]   live_r, live_nxt;

  logic [STAT_W-1:0]  status_r, status_nxt;
  logic [HIDX_W-1:0]  slot_idx_r, slot_idx_nxt;
  logic [HGEN_W-1:0]  slot_gen_r, slot_gen_nxt;
  logic               is_live_r, is_live_nxt;
  logic [LCNT_W-1:0]  live_cnt_r;

  logic [IDX_W-1:0]   rd_addr;
  logic [IDX_W-1:0]   wr_addr;
  logic [WORD_W-1:0]  wr_data;
  logic               wr_en;

  logic               rd_live;
  logic [GEN_WIDTH-1:0] rd_gen;
  logic [LINK_W-1:0]  rd_next;
  logic [GEN_WIDTH-1:0] gen_inc;
  logic               current;
  logic [31:0]        live_wide;

  assign rd_live = rd_r[WORD_W-1];
  assign rd_gen  = rd_r[GEN_WIDTH+LINK_W-1:LINK_W];
  assign rd_next = rd_r[LINK_W-1:0];

  always_comb begin
    if (in_func == FUNC_ALLOC) begin
      rd_addr = free_head_r[IDX_W-1:0];
    end else begin
      rd_addr = IDX_W'(32'(in_handle_index));
    end
  end

  assign current = (gen_r != '0)
                && (32'(idx_r) < 32'(high_water_r))
                && (32'(idx_r) < SLOTS)
                && rd_live
                && (32'(rd_gen) == 32'(gen_r));

  assign gen_inc = (rd_gen + GEN_ONE == '0) ? GEN_ONE : rd_gen + GEN_ONE;

  always_comb begin
    free_head_nxt  = free_head_r;
    high_water_nxt = high_water_r;
    live_nxt       = live_r;
    status_nxt     = STAT_OK;
    slot_idx_nxt   = '0;
    slot_gen_nxt   = '0;
    is_live_nxt    = 1'b0;
    wr_en          = 1'b0;
    wr_addr        = IDX_W'(32'(idx_r));
    wr_data        = {1'b0, gen_inc, free_head_r};
    unique case (func_r)
      FUNC_ALLOC: begin
        if (!free_head_r[IDX_W]) begin
          wr_en         = 1'b1;
          wr_addr       = free_head_r[IDX_W-1:0];
          wr_data       = {1'b1, rd_gen, LINK_NULL};
          free_head_nxt = rd_next;
          live_nxt      = live_r + CNT_W'(1);
          slot_idx_nxt  = HIDX_W'(32'(free_head_r[IDX_W-1:0]));
          slot_gen_nxt  = HGEN_W'(rd_gen);
        end else if (32'(high_water_r) < SLOTS) begin
          wr_en          = 1'b1;
          wr_addr        = high_water_r[IDX_W-1:0];
          wr_data        = {1'b1, GEN_ONE, LINK_NULL};
          high_water_nxt = high_water_r + CNT_W'(1);
          live_nxt       = live_r + CNT_W'(1);
          slot_idx_nxt   = HIDX_W'(32'(high_water_r[IDX_W-1:0]));
          slot_gen_nxt   = HGEN_W'(GEN_ONE);
        end else begin
          status_nxt = STAT_FULL;
        end
      end
      FUNC_RELEASE: begin
        if (current) begin
          wr_en         = 1'b1;
          free_head_nxt = {1'b0, IDX_W'(32'(idx_r))};
          if (live_r != '0) begin
            live_nxt = live_r - CNT_W'(1);
          end
        end else begin
          status_nxt = STAT_STALE;
        end
      end
      FUNC_QUERY: begin
        is_live_nxt = current;
      end
      default: begin
      end
    endcase
  end

  assign live_wide = 32'(live_nxt);

  always_ff @(posedge clk) begin
    if (cmd.commit && wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.capture) begin
      rd_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r <= in_func;
      idx_r  <= in_handle_index;
      gen_r  <= in_handle_generation;
    end
    if (cmd.commit) begin
      status_r   <= status_nxt;
      slot_idx_r <= slot_idx_nxt;
      slot_gen_r <= slot_gen_nxt;
      is_live_r  <= is_live_nxt;
      live_cnt_r <= live_wide[LCNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_head_r  <= LINK_NULL;
      high_water_r <= '0;
      live_r       <= '0;
    end else if (cmd.commit) begin
      free_head_r  <= free_head_nxt;
      high_water_r <= high_water_nxt;
      live_r       <= live_nxt;
    end
  end

  assign out_status          = status_r;
  assign out_slot_index      = slot_idx_r;
  assign out_slot_generation = slot_gen_r;
  assign out_is_live         = is_live_r;
  assign out_live_count      = live_cnt_r;

endmodule

`default_nettype wire
